### src/cfl_tsmr_pkg.sv
// Package for the stable time step reduction block.
// Holds the payload structs, the shared-unit request types and register codes.
// No dependencies.
`timescale 1ns / 1ps

package cfl_tsmr_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned SfW     = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumW    = 80;   // widest dividend: dx^2 * 2^16
  localparam int unsigned DenW    = 37;   // widest divisor: 20 * speed
  localparam int unsigned RadW    = 64;   // radicand: sum of three squares

  localparam logic [DataW-1:0] ALL_ONES     = '1;
  localparam logic [DataW-1:0] PRANDTL_RST  = 32'h0100_0000;
  localparam logic [SfW-1:0]   SAFETY_RST   = 16'h1000;
  // 0.2 * dx^2 in Q8.24 from a Q32.32 square is dx^2 * 2^-8 / 5
  localparam logic [DenW-1:0]  THERMAL_DEN  = 37'd1280;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRANDTL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SAFETY  = 2'd2;

  typedef struct packed {
    logic        [31:0] cell_volume;
    logic        [31:0] face_area;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] viscosity;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] time_step;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [RadW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] root;
  } sqrt_rsp_t;

endpackage

### src/cfl_tsmr_div.sv
// Iterative restoring divider, two quotient bits per cycle, 32-bit saturating quotient.
// Gives min(floor(num / den), all ones); a zero divisor saturates.
// Depends on cfl_tsmr_pkg.
`timescale 1ns / 1ps

module cfl_tsmr_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfl_tsmr_pkg::div_req_t req,
  output cfl_tsmr_pkg::div_rsp_t rsp
);
  import cfl_tsmr_pkg::*;

  logic [3:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DenW-1:0]  den_r;
  logic [DenW-1:0]  rem_r;
  logic [DataW-1:0] low_r;
  logic [DataW-1:0] quot_r;

  logic [DenW-1:0]  rem_nxt;
  logic [DataW-1:0] low_nxt;
  logic [DataW-1:0] quot_nxt;
  logic [DenW:0]    trial;
  logic             ovf;

  // The quotient fits 32 bits exactly when the upper dividend part is below the divisor.
  assign ovf = (req.num[NumW-1:DataW] >= {{(NumW-DataW-DenW){1'b0}}, req.den});

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quot_nxt = quot_r;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_nxt, low_nxt[DataW-1]};
      if (trial >= {1'b0, den_r}) begin
        trial = trial - {1'b0, den_r};
        quot_nxt = {quot_nxt[DataW-2:0], 1'b1};
      end else begin
        quot_nxt = {quot_nxt[DataW-2:0], 1'b0};
      end
      rem_nxt = trial[DenW-1:0];
      low_nxt = {low_nxt[DataW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (ovf) begin
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 4'd15;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den_r  <= req.den;
      rem_r  <= req.num[DataW+DenW-1:DataW];
      low_r  <= req.num[DataW-1:0];
      quot_r <= ovf ? ALL_ONES : '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

### src/cfl_tsmr_sqrt.sv
// Iterative integer square root of a 64-bit value, two root bits per cycle.
// Exact floor root; the root is valid while its done flag is high.
// Depends on cfl_tsmr_pkg.
`timescale 1ns / 1ps

module cfl_tsmr_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfl_tsmr_pkg::sqrt_req_t req,
  output cfl_tsmr_pkg::sqrt_rsp_t rsp
);
  import cfl_tsmr_pkg::*;

  logic [3:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [RadW-1:0]  rad_r;
  logic [33:0]      rem_r;
  logic [DataW-1:0] root_r;

  logic [RadW-1:0]  rad_nxt;
  logic [33:0]      rem_nxt;
  logic [DataW-1:0] root_nxt;
  logic [35:0]      acc;
  logic [35:0]      trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    acc      = '0;
    trial    = '0;
    for (int i = 0; i < 2; i++) begin
      acc   = {rem_nxt, rad_nxt[RadW-1:RadW-2]};
      trial = {2'b00, root_nxt, 2'b01};
      if (acc >= trial) begin
        acc      = acc - trial;
        root_nxt = {root_nxt[DataW-2:0], 1'b1};
      end else begin
        root_nxt = {root_nxt[DataW-2:0], 1'b0};
      end
      // The partial remainder never exceeds twice the partial root.
      rem_nxt = acc[33:0];
      rad_nxt = {rad_nxt[RadW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd15;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rad_r  <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

### src/cfl_time_step_min_reduce.sv
// Top level of the stable time step reduction: sequencer, shared multiplier, limit minimum.
// Instantiates cfl_tsmr_div and cfl_tsmr_sqrt; depends on cfl_tsmr_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in_     | input     | in_valid / in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid / out_stall| out_data (out_item_t)
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// While an item is worked on, in_stall stays high. The transfer cycle, the squaring and
// the square root come first (the spacing divide runs under them), then each limit
// divide runs on the shared 2-bit-per-cycle divider, the thermal one in Prandtl mode
// only, then the closing state. A skipped limit or a divide known to clip does not iterate.
// An item with last set adds a product state that waits for out_stall to release.
// Reset is synchronous and active low; it clears the minimum and the result valid flag.
// The finished result sits in an output register, so the next item is taken while it waits.
`timescale 1ns / 1ps

module cfl_time_step_min_reduce (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cfl_tsmr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cfl_tsmr_pkg::out_item_t out_data,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_wdata
);
  import cfl_tsmr_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_MX       = 15'b000000000000010,
    S_MY       = 15'b000000000000100,
    S_MZ       = 15'b000000000001000,
    S_SUM      = 15'b000000000010000,
    S_SQRT     = 15'b000000000100000,
    S_WAIT     = 15'b000000001000000,
    S_DXSQ     = 15'b000000010000000,
    S_CONV     = 15'b000000100000000,
    S_DIFF_GO  = 15'b000001000000000,
    S_DIFF     = 15'b000010000000000,
    S_THERM_GO = 15'b000100000000000,
    S_THERM    = 15'b001000000000000,
    S_FIN      = 15'b010000000000000,
    S_PROD     = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic             mode_r;
  logic [DataW-1:0] prandtl_r;
  logic [SfW-1:0]   safety_r;

  // Item registers
  logic [DataW-1:0] vol_r, area_r, visc_r, ax_r, ay_r, az_r;
  logic             last_r;

  // Datapath
  logic [DataW-1:0]   mul_a, mul_b;
  logic [2*DataW-1:0] prod_r;
  logic [2*DataW-1:0] sum_r;
  logic [DataW-1:0]   dx_r, speed_r;
  logic               dx_ok_r, sp_ok_r;
  logic [DataW-1:0]   run_min_r;
  logic               any_fin_r;
  logic [DataW-1:0]   nu;
  logic               take_lim;
  logic               out_free;
  logic               prod_ovf;
  out_item_t          result;
  out_item_t          out_r;
  logic               out_valid_r;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  function automatic logic [DataW-1:0] mag(input logic [DataW-1:0] v);
    mag = v[DataW-1] ? (~v + 32'd1) : v;
  endfunction

  assign nu       = mode_r ? prandtl_r : visc_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      prandtl_r <= PRANDTL_RST;
      safety_r  <= SAFETY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:    mode_r    <= cfg_wdata[0];
        CFG_PRANDTL: prandtl_r <= cfg_wdata;
        CFG_SAFETY:  safety_r  <= cfg_wdata[SfW-1:0];
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_MX;
      S_MX:       state_nxt = S_MY;
      S_MY:       state_nxt = S_MZ;
      S_MZ:       state_nxt = S_SUM;
      S_SUM:      state_nxt = S_SQRT;
      S_SQRT:     state_nxt = S_WAIT;
      S_WAIT:     if (dx_ok_r && sp_ok_r) state_nxt = S_DXSQ;
      S_DXSQ:     state_nxt = S_CONV;
      S_CONV:     if (speed_r == '0 || div_rsp.done) state_nxt = S_DIFF_GO;
      S_DIFF_GO:  state_nxt = S_DIFF;
      S_DIFF: begin
        if (nu == '0 || div_rsp.done) state_nxt = mode_r ? S_THERM_GO : S_FIN;
      end
      S_THERM_GO: state_nxt = S_THERM;
      S_THERM:    if (div_rsp.done) state_nxt = S_FIN;
      S_FIN:      state_nxt = last_r ? S_PROD : S_IDLE;
      S_PROD:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- shared multiplier
  // Outside the squaring and final-product states the operands rest on dx, so prod_r
  // holds dx^2 from the convective step until the sweep result is formed.
  always_comb begin
    mul_a = dx_r;
    mul_b = dx_r;
    unique case (state_r) inside
      S_MX: begin
        mul_a = ax_r;
        mul_b = ax_r;
      end
      S_MY: begin
        mul_a = ay_r;
        mul_b = ay_r;
      end
      S_MZ: begin
        mul_a = az_r;
        mul_b = az_r;
      end
      S_FIN, S_PROD: begin
        mul_a = run_min_r;
        mul_b = {{(DataW-SfW){1'b0}}, safety_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r) inside
      S_MY:         sum_r <= prod_r;
      S_MZ, S_SUM:  sum_r <= sum_r + prod_r;
      default:      ;
    endcase
  end

  // ---------------------------------------------------------------- shared units
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    unique case (state_r)
      S_MX: begin
        div_req.start = 1'b1;
        div_req.num   = {32'd0, vol_r, 16'd0};
        div_req.den   = {5'd0, area_r};
      end
      S_DXSQ: begin
        div_req.start = (speed_r != '0);
        div_req.num   = {21'd0, ({dx_r, 3'b000} - {3'b000, dx_r}), 24'd0};
        div_req.den   = {1'b0, speed_r, 4'b0000} + {3'b000, speed_r, 2'b00};
      end
      S_DIFF_GO: begin
        div_req.start = (nu != '0);
        div_req.num   = {prod_r, 16'd0};
        div_req.den   = {2'b00, ({1'b0, nu, 2'b00} + {3'b000, nu})};
      end
      S_THERM_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {16'd0, prod_r};
        div_req.den   = THERMAL_DEN;
      end
      default: ;
    endcase
  end

  assign sqrt_req.start    = (state_r == S_SQRT);
  assign sqrt_req.radicand = sum_r;

  cfl_tsmr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  cfl_tsmr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // ---------------------------------------------------------------- item capture
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      vol_r  <= in_data.cell_volume;
      area_r <= in_data.face_area;
      visc_r <= in_data.viscosity;
      ax_r   <= mag(in_data.vel_x);
      ay_r   <= mag(in_data.vel_y);
      az_r   <= mag(in_data.vel_z);
      last_r <= in_data.last;
    end
    // The first divide after a transfer is always the spacing.
    if (div_rsp.done && !dx_ok_r) dx_r <= div_rsp.quot;
    if (sqrt_rsp.done) speed_r <= sqrt_rsp.root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_ok_r <= 1'b0;
      sp_ok_r <= 1'b0;
    end else if (state_r == S_IDLE) begin
      dx_ok_r <= 1'b0;
      sp_ok_r <= 1'b0;
    end else begin
      if (div_rsp.done) dx_ok_r <= 1'b1;
      if (sqrt_rsp.done) sp_ok_r <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- running minimum
  assign take_lim = div_rsp.done &&
                    (state_r == S_CONV || state_r == S_DIFF || state_r == S_THERM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r <= ALL_ONES;
      any_fin_r <= 1'b0;
    end else if (state_r == S_PROD && out_free) begin
      run_min_r <= ALL_ONES;
      any_fin_r <= 1'b0;
    end else if (take_lim) begin
      any_fin_r <= 1'b1;
      if (div_rsp.quot < run_min_r) run_min_r <= div_rsp.quot;
    end
  end

  // ---------------------------------------------------------------- result
  // prod_r holds run_min * safety (a Q4.12 scale) here.
  assign prod_ovf = (prod_r[47:44] != 4'd0);

  always_comb begin
    if (!any_fin_r) begin
      result.time_step = ALL_ONES;
      result.saturated = 1'b1;
    end else if (prod_ovf) begin
      result.time_step = ALL_ONES;
      result.saturated = 1'b1;
    end else begin
      result.time_step = prod_r[43:12];
      result.saturated = (run_min_r == ALL_ONES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_PROD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PROD && out_free) out_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### src/cfl_tsmr_chk.sv
// Port-level checker for the stable time step reduction block, bound to the top level.
// Depends on cfl_tsmr_pkg and cfl_time_step_min_reduce.
`timescale 1ns / 1ps

module cfl_tsmr_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input cfl_tsmr_pkg::out_item_t out_data
);
  import cfl_tsmr_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // An input transfer starts a multi-cycle computation, so the next cycle is stalled.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // A new result only appears at the end of an item's computation.
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a computation");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cfl_time_step_min_reduce cfl_tsmr_chk u_cfl_tsmr_chk (.*);

### tb/tb.sv
// Self-checking testbench for cfl_time_step_min_reduce: drives cells and register settings,
// predicts each sweep's stable time step and checks every result transfer against it.
// Depends on cfl_tsmr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import cfl_tsmr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned PHASE_CELLS    = 90;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned HOLD_PHASE     = 3;

  // Tracks the sweep minimum in the block's fixed-point formats and queues
  // the time step that each closing cell must produce.
  class time_step_board;
    bit              mode;
    logic [31:0]     prandtl;
    logic [15:0]     safety;
    logic [31:0]     cur_min;
    bit              seen_limit;
    out_item_t       expected_steps[$];
    int unsigned     mismatches;
    int unsigned     steps_checked;

    function new();
      mode          = 1'b0;
      prandtl       = PRANDTL_RST;
      safety        = SAFETY_RST;
      cur_min       = ALL_ONES;
      seen_limit    = 1'b0;
      mismatches    = 0;
      steps_checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_MODE:    mode = val[0];
        CFG_PRANDTL: prandtl = val;
        CFG_SAFETY:  safety = val[15:0];
        default: ;
      endcase
    endfunction

    // Floor of num/den, clipped to 32 bits; a zero divisor gives all ones.
    function logic [31:0] clip_quot(logic [127:0] num, logic [63:0] den);
      logic [127:0] q;
      if (den == 0) return ALL_ONES;
      q = num / den;
      return (q > 128'hFFFF_FFFF) ? ALL_ONES : q[31:0];
    endfunction

    function logic [31:0] root_floor(logic [67:0] x);
      logic [32:0] r;
      logic [32:0] t;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        t = r | (33'd1 << b);
        if (68'(t) * 68'(t) <= x) r = t;
      end
      return r[31:0];
    endfunction

    function logic [32:0] abs_vel(logic signed [31:0] v);
      return v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
    endfunction

    function void lower_min(logic [31:0] lim);
      if (lim < cur_min) cur_min = lim;
      seen_limit = 1'b1;
    endfunction

    function void fold_cell(in_item_t c);
      logic [127:0] dx;
      logic [127:0] dx2;
      logic [32:0]  ax;
      logic [32:0]  ay;
      logic [32:0]  az;
      logic [67:0]  sq_sum;
      logic [31:0]  speed;
      logic [31:0]  nu;
      logic [47:0]  scaled;
      out_item_t    step;
      dx     = clip_quot({c.cell_volume, 16'h0}, {32'h0, c.face_area});
      dx2    = dx * dx;
      ax     = abs_vel(c.vel_x);
      ay     = abs_vel(c.vel_y);
      az     = abs_vel(c.vel_z);
      sq_sum = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay) + 68'(az) * 68'(az);
      speed  = root_floor(sq_sum);
      if (speed != 0) lower_min(clip_quot((dx * 7) << 24, 64'(speed) * 20));
      nu = mode ? prandtl : c.viscosity;
      if (nu != 0) lower_min(clip_quot(dx2 << 16, 64'(nu) * 5));
      if (mode) lower_min(clip_quot(dx2, 64'(THERMAL_DEN)));
      if (c.last) begin
        if (!seen_limit) begin
          step.time_step = ALL_ONES;
          step.saturated = 1'b1;
        end else begin
          scaled = (48'(cur_min) * 48'(safety)) >> 12;
          step.saturated = (cur_min == ALL_ONES) || (scaled > 48'hFFFF_FFFF);
          step.time_step = (scaled > 48'hFFFF_FFFF) ? ALL_ONES : scaled[31:0];
        end
        expected_steps = {expected_steps, step};
        cur_min    = ALL_ONES;
        seen_limit = 1'b0;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_steps.size() == 0) begin
        report($sformatf("time step %h arrived with none expected", got.time_step));
        return;
      end
      want = expected_steps.pop_front();
      steps_checked++;
      if (got.time_step !== want.time_step)
        report($sformatf("time_step %h, expected %h", got.time_step, want.time_step));
      if (got.saturated !== want.saturated)
        report($sformatf("saturated %b, expected %b", got.saturated, want.saturated));
    endtask

    function int unsigned pending();
      return expected_steps.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  time_step_board board;
  bit             tx_steady;
  bit             rx_steady;
  bit             hold_req;
  bit             moved;
  int unsigned    quiet_cycles;
  int unsigned    cells_sent;
  int unsigned    settings_used;

  cfl_time_step_min_reduce u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transfers are sampled at the edge, so both sides see pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        board.fold_cell(in_data);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Result side: a random stall before each transfer, or one long hold on request.
  initial begin
    int unsigned n;
    out_stall <= 1'b0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = rx_steady ? 0 : $urandom_range(0, 19);
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic in_item_t mk_cell(logic [31:0] vol, logic [31:0] area,
                                       logic [31:0] vx, logic [31:0] vy,
                                       logic [31:0] vz, logic [31:0] visc, bit last);
    in_item_t c;
    c.cell_volume = vol;
    c.face_area   = area;
    c.vel_x       = vx;
    c.vel_y       = vy;
    c.vel_z       = vz;
    c.viscosity   = visc;
    c.last        = last;
    return c;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0;
      1:       return ALL_ONES;
      2:       return $urandom_range(1, 255);
      3:       return 32'h1 << $urandom_range(0, 31);
      4, 5:    return $urandom_range(32'h0000_4000, 32'h0004_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_vel();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = 32'h0;
      1:       v = 32'h8000_0000;
      2:       v = 32'h7FFF_FFFF;
      3, 4:    v = $urandom_range(0, 32'h0010_0000);
      default: v = $urandom();
    endcase
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic in_item_t rand_cell(bit last);
    in_item_t c;
    c = mk_cell(rand_word(), rand_word(), rand_vel(), rand_vel(), rand_vel(),
                rand_word(), last);
    if (c.face_area == 0) c.face_area = 32'h1;
    // Still cells exercise the skipped convective limit.
    if ($urandom_range(0, 7) == 0) begin
      c.vel_x = '0;
      c.vel_y = '0;
      c.vel_z = '0;
    end
    return c;
  endfunction

  // in_valid stays high across back-to-back transfers; a gap lowers it in the
  // same step as the previous transfer.
  task automatic send_cell(in_item_t c);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (in_stall);
    cells_sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // A cell without last may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(bit m, logic [31:0] pr, logic [15:0] sf);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MODE;
    cfg_wdata <= {31'h0, m};
    @(posedge clk);
    cfg_index <= CFG_PRANDTL;
    cfg_wdata <= pr;
    @(posedge clk);
    cfg_index <= CFG_SAFETY;
    cfg_wdata <= {16'h0, sf};
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(CFG_MODE, {31'h0, m});
    board.write_reg(CFG_PRANDTL, pr);
    board.write_reg(CFG_SAFETY, {16'h0, sf});
    settings_used++;
  endtask

  initial begin
    logic [31:0] pr;
    logic [15:0] sf;
    int unsigned phase_cells;
    int unsigned sweep_len;
    bit          broken;
    board         = new();
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    hold_req      = 1'b0;
    quiet_cycles  = 0;
    cells_sent    = 0;
    settings_used = 1;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_MODE;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Viscosity mode with the reset settings.
    send_cell(mk_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'd167772, 1));
    send_cell(mk_cell(32'h0002_0000, 32'h0001_0000, 0, 0, 0, 32'h0010_0000, 1));
    send_cell(mk_cell(32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 1));
    // Nothing limits this sweep.
    send_cell(mk_cell(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 1));
    // Spacing clips, so the one limit seen clips as well.
    send_cell(mk_cell(ALL_ONES, 32'h1, 32'h1, 0, 0, 0, 1));
    send_cell(mk_cell(0, ALL_ONES, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, ALL_ONES, 0));
    send_cell(mk_cell(ALL_ONES, ALL_ONES, ALL_ONES, 32'h1, 0, 32'h1, 0));
    send_cell(mk_cell(32'h0003_0000, 32'h0001_8000, 32'h0000_4000, 32'hFFFF_C000,
                      32'h0002_0000, 32'h0004_0000, 1));
    drain_and_settle();

    // Prandtl mode at the smallest number and largest safety factor; the thermal
    // limit alone overflows the scaled product.
    configure(1'b1, 32'h1, 16'hFFFF);
    send_cell(mk_cell(32'h0010_0000, 32'h0001_0000, 0, 0, 0, 0, 1));
    send_cell(mk_cell(32'h0001_0000, 32'h0000_8000, 32'h0003_0000, 32'h0001_0000,
                      32'hFFFE_0000, 0, 1));
    drain_and_settle();

    configure(1'b1, ALL_ONES, 16'h0000);
    send_cell(mk_cell(ALL_ONES, 32'h1, 0, 0, 0, 32'h1234_5678, 1));
    send_cell(mk_cell(32'h0000_8000, 32'h0001_0000, 32'h0000_1000, 0, 0, 0, 1));
    drain_and_settle();

    configure(1'b0, 32'h0100_0000, 16'hFFFF);
    send_cell(mk_cell(32'h0100_0000, 32'h0001_0000, 0, 0, 0, 32'h0000_0001, 1));
    send_cell(mk_cell(32'h0000_0100, 32'h0001_0000, 32'h0000_0001, 0, 0, 32'h0100_0000, 0));
    send_cell(mk_cell(32'h0001_0000, 32'h0001_0000, 0, 32'h0000_2000, 0, 0, 1));
    drain_and_settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       pr = 32'h1;
        1:       pr = ALL_ONES;
        2:       pr = 32'h0100_0000;
        default: pr = $urandom_range(1, 32'hFFFF_FFFF);
      endcase
      case ($urandom_range(0, 3))
        0:       sf = 16'h0000;
        1:       sf = 16'hFFFF;
        2:       sf = 16'h1000;
        default: sf = 16'($urandom_range(0, 16'hFFFF));
      endcase
      configure(p[0], pr, sf);
      tx_steady = (p % 3 == 1);
      rx_steady = (p % 3 == 1);
      phase_cells = 0;
      if (p == HOLD_PHASE) begin
        // The result side holds off while single-cell sweeps keep arriving.
        hold_req = 1'b1;
        for (int k = 0; k < 8; k++) begin
          send_cell(rand_cell(1'b1));
          phase_cells++;
        end
      end
      while (phase_cells < PHASE_CELLS) begin
        sweep_len = $urandom_range(1, 8);
        broken    = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < sweep_len; k++) begin
          send_cell(rand_cell((k == sweep_len - 1) && !broken));
          phase_cells++;
        end
      end
      drain_and_settle();
    end

    $display("Run covered %0d cells and %0d sweep time steps under %0d register settings,",
             cells_sent, board.steps_checked, settings_used);
    $display("both limit modes, saturation cases and a long result-side hold.");
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
